// ===== hdl/qndp_pkg.sv =====
package qndp_pkg;

  localparam int unsigned NibbleW = 4;
  localparam int unsigned ByteW   = 2 * NibbleW;
  localparam int unsigned CoefW   = 16;
  // A restored element is scale * code + min, exact in 21 signed bits.
  localparam int unsigned ElemW   = CoefW + NibbleW + 1;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned AccW    = 64;

  typedef struct packed {
    logic valid;
    logic last;
  } qndp_ctl_t;

endpackage

// ===== hdl/qndp_lane.sv =====
module qndp_lane
  import qndp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [NibbleW-1:0]       x_code_i,
  input  logic [NibbleW-1:0]       y_code_i,
  input  logic signed [CoefW-1:0]  x_scale_i,
  input  logic signed [CoefW-1:0]  x_min_i,
  input  logic signed [CoefW-1:0]  y_scale_i,
  input  logic signed [CoefW-1:0]  y_min_i,
  output logic signed [ProdW-1:0]  prod_o
);

  logic signed [ElemW-1:0] x_elem_d, x_elem_q;
  logic signed [ElemW-1:0] y_elem_d, y_elem_q;
  logic signed [ProdW-1:0] prod_d, prod_q;

  // The code is unsigned, so it gets a zero sign bit before the signed multiply.
  always_comb begin
    x_elem_d = ElemW'(x_scale_i) * ElemW'($signed({1'b0, x_code_i})) + ElemW'(x_min_i);
    y_elem_d = ElemW'(y_scale_i) * ElemW'($signed({1'b0, y_code_i})) + ElemW'(y_min_i);
    prod_d   = ProdW'(x_elem_q) * ProdW'(y_elem_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_elem_q <= x_elem_d;
      y_elem_q <= y_elem_d;
      prod_q   <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/qndp_merge.sv =====
module qndp_merge
  import qndp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  qndp_ctl_t                ctl_i,
  input  logic signed [ProdW-1:0]  prod_lo_i,
  input  logic signed [ProdW-1:0]  prod_hi_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [AccW-1:0]   dot_sum_o
);

  logic [AccW-1:0] acc_d, acc_q;
  logic [AccW-1:0] sum;
  logic [AccW-1:0] dot_d, dot_q;
  logic            out_valid_d, out_valid_q;
  logic            take;

  always_comb begin
    take        = en_i && ctl_i.valid;
    sum         = acc_q + AccW'(prod_lo_i) + AccW'(prod_hi_i);
    acc_d       = acc_q;
    dot_d       = dot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      if (ctl_i.last) begin
        // The finished sum moves to the output and the accumulator restarts.
        acc_d       = '0;
        dot_d       = sum;
        out_valid_d = 1'b1;
      end else begin
        acc_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q <= dot_d;
  end

  assign out_valid_o = out_valid_q;
  assign dot_sum_o   = dot_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(take && ctl_i.last))
    else $error("waiting result overwritten");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && ctl_i.last) |=> (acc_q == '0))
    else $error("accumulator not cleared after a result");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && ctl_i.last) |=> out_valid_q)
    else $error("closing transaction produced no result");

  a_acc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(acc_q))
    else $error("accumulator changed without a transaction");

endmodule

// ===== hdl/quantized_nibble_dot_product_core.sv =====
// Each pair passes the element, product and result registers before dot_sum_o.
// Throughput: one byte pair per cycle; two lanes (low and high nibble) restore and
// multiply side by side, and one 64-bit accumulator merges both products per cycle.
// The input stalls only when a closing pair meets an output result not yet taken.
// Reset clears the pipeline valids, the running sum and the output valid.
module quantized_nibble_dot_product_core
  import qndp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ByteW-1:0]         x_byte_i,
  input  logic [ByteW-1:0]         y_byte_i,
  input  logic signed [CoefW-1:0]  x_scale_i,
  input  logic signed [CoefW-1:0]  x_min_i,
  input  logic signed [CoefW-1:0]  y_scale_i,
  input  logic signed [CoefW-1:0]  y_min_i,
  input  logic                     last_pair_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [AccW-1:0]   dot_sum_o
);

  qndp_ctl_t s1_d, s1_q, s2_q;
  logic      adv;
  logic signed [ProdW-1:0] prod_lo, prod_hi;

  // The pipeline only halts when a closing transaction reaches the merge
  // stage while the previous result still waits.
  assign adv        = !(s2_q.valid && s2_q.last && out_valid_o && !out_ready_i);
  assign in_ready_o = adv;

  always_comb begin
    s1_d.valid = in_valid_i;
    s1_d.last  = last_pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  qndp_lane u_lane_lo (
    .clk_i     (clk_i),
    .en_i      (adv),
    .x_code_i  (x_byte_i[NibbleW-1:0]),
    .y_code_i  (y_byte_i[NibbleW-1:0]),
    .x_scale_i (x_scale_i),
    .x_min_i   (x_min_i),
    .y_scale_i (y_scale_i),
    .y_min_i   (y_min_i),
    .prod_o    (prod_lo)
  );

  qndp_lane u_lane_hi (
    .clk_i     (clk_i),
    .en_i      (adv),
    .x_code_i  (x_byte_i[ByteW-1:NibbleW]),
    .y_code_i  (y_byte_i[ByteW-1:NibbleW]),
    .x_scale_i (x_scale_i),
    .x_min_i   (x_min_i),
    .y_scale_i (y_scale_i),
    .y_min_i   (y_min_i),
    .prod_o    (prod_hi)
  );

  qndp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .ctl_i       (s2_q),
    .prod_lo_i   (prod_lo),
    .prod_hi_i   (prod_hi),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .dot_sum_o   (dot_sum_o)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import qndp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned BlockPairs    = 16;
  // One long vector keeps large products accumulating over many pairs.
  localparam int unsigned LongPairs     = 500;

  // Holds the expected dot products and the sum of the vector in flight.
  class dot_scoreboard;
    logic signed [AccW-1:0] partial_sum;
    logic signed [AccW-1:0] sums_due[$];
    int errors;
    int pairs_taken;
    int sums_checked;

    function new();
      partial_sum  = '0;
      errors       = 0;
      pairs_taken  = 0;
      sums_checked = 0;
    endfunction

    function longint dequant(logic signed [CoefW-1:0] scale, logic signed [CoefW-1:0] offset,
                             logic [NibbleW-1:0] code);
      return longint'(scale) * longint'({1'b0, code}) + longint'(offset);
    endfunction

    function void note_pair(logic [ByteW-1:0] xb, logic [ByteW-1:0] yb,
                            logic signed [CoefW-1:0] xs, logic signed [CoefW-1:0] xm,
                            logic signed [CoefW-1:0] ys, logic signed [CoefW-1:0] ym,
                            logic last);
      longint lo_prod;
      longint hi_prod;
      lo_prod = dequant(xs, xm, xb[NibbleW-1:0]) * dequant(ys, ym, yb[NibbleW-1:0]);
      hi_prod = dequant(xs, xm, xb[ByteW-1:NibbleW]) * dequant(ys, ym, yb[ByteW-1:NibbleW]);
      partial_sum = partial_sum + lo_prod + hi_prod;
      pairs_taken++;
      if (last) begin
        sums_due.push_back(partial_sum);
        partial_sum = '0;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_sum(logic signed [AccW-1:0] got);
      logic signed [AccW-1:0] want;
      if (sums_due.size() == 0) begin
        report($sformatf("dot_sum %0d with no transaction pending", got));
      end else begin
        want = sums_due.pop_front();
        sums_checked++;
        if (got !== want) begin
          report($sformatf("dot_sum got %0d expected %0d", got, want));
        end
      end
    endtask

    function int pending();
      return sums_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ByteW-1:0] x_byte_i = '0;
  logic [ByteW-1:0] y_byte_i = '0;
  logic signed [CoefW-1:0] x_scale_i = '0;
  logic signed [CoefW-1:0] x_min_i = '0;
  logic signed [CoefW-1:0] y_scale_i = '0;
  logic signed [CoefW-1:0] y_min_i = '0;
  logic last_pair_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [AccW-1:0] dot_sum_o;

  dot_scoreboard sb = new();
  logic idle_on = 1'b1;
  int ready_hold = 0;
  int quiet_cycles = 0;

  quantized_nibble_dot_product_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_byte_i   (x_byte_i),
    .y_byte_i   (y_byte_i),
    .x_scale_i  (x_scale_i),
    .x_min_i    (x_min_i),
    .y_scale_i  (y_scale_i),
    .y_min_i    (y_min_i),
    .last_pair_i(last_pair_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dot_sum_o  (dot_sum_o)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: ready drops in bursts while idling is on.
  initial begin
    forever begin
      @(negedge clk_i);
      if (ready_hold != 0) begin
        ready_hold--;
      end else if (idle_on && out_ready_i) begin
        out_ready_i = 1'b0;
        ready_hold  = $urandom_range(0, 18);
      end else begin
        out_ready_i = 1'b1;
        ready_hold  = idle_on ? $urandom_range(0, 30) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_sum(dot_sum_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pair(logic [ByteW-1:0] xb, logic [ByteW-1:0] yb,
                           logic signed [CoefW-1:0] xs, logic signed [CoefW-1:0] xm,
                           logic signed [CoefW-1:0] ys, logic signed [CoefW-1:0] ym,
                           logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    x_byte_i    = xb;
    y_byte_i    = yb;
    x_scale_i   = xs;
    x_min_i     = xm;
    y_scale_i   = ys;
    y_min_i     = ym;
    last_pair_i = last;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(xb, yb, xs, xm, ys, ym, last);
  endtask

  // Holds off the sender until every dot product has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return CoefW'(-32768);
      1: return CoefW'(32767);
      2: return CoefW'(0);
      3: return CoefW'(-1);
      4, 5: return CoefW'($urandom_range(0, 1023) - 512);
      6: return CoefW'(256);
      default: return CoefW'($urandom());
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return ByteW'($urandom());
    endcase
  endfunction

  task automatic send_vector(int unsigned n_pairs);
    logic signed [CoefW-1:0] xs, xm, ys, ym;
    for (int unsigned i = 0; i < n_pairs; i++) begin
      // New coefficients at each block start, and now and then mid-block.
      if (i % BlockPairs == 0 || $urandom_range(0, 9) == 0) begin
        xs = pick_coef();
        xm = pick_coef();
        ys = pick_coef();
        ym = pick_coef();
      end
      send_pair(pick_byte(), pick_byte(), xs, xm, ys, ym, i == n_pairs - 1);
    end
  endtask

  task automatic send_random_vectors(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      if (len > n_items - sent) len = n_items - sent;
      send_vector(len);
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single-pair vectors at the corners of the coefficient range.
    send_pair(8'h00, 8'h00, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_pair(8'hff, 8'hff, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
    send_pair(8'hff, 8'hff, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1);
    send_pair(8'hff, 8'hff, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);
    send_pair(8'h00, 8'hff, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b1);
    // Nibble order: the nonzero codes sit in one nibble only or differ between nibbles.
    send_pair(8'h0f, 8'hf0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1);
    send_pair(8'hf0, 8'h0f, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1);
    send_pair(8'h0f, 8'h0f, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1);
    send_pair(8'h5a, 8'ha5, -16'sd1, 16'sd128, 16'sd77, -16'sd300, 1'b1);
    // Pairs that only accumulate, then the closing pair.
    send_pair(8'h12, 8'h34, 16'sd300, -16'sd50, 16'sd20, 16'sd10, 1'b0);
    send_pair(8'h56, 8'h78, 16'sd300, -16'sd50, 16'sd20, 16'sd10, 1'b0);
    send_pair(8'h9a, 8'hbc, 16'sd300, -16'sd50, 16'sd20, 16'sd10, 1'b0);
    send_pair(8'hde, 8'hf0, 16'sd300, -16'sd50, 16'sd20, 16'sd10, 1'b1);
    // Coefficients that change from pair to pair inside one block.
    send_pair(8'hff, 8'h11, 16'sd32767, -16'sd32768, 16'sd1, 16'sd0, 1'b0);
    send_pair(8'h80, 8'h08, -16'sd32768, 16'sd32767, -16'sd2, 16'sd5, 1'b0);
    send_pair(8'h3c, 8'hc3, 16'sd1000, -16'sd1000, 16'sd32767, -16'sd32768, 1'b1);
    // Back-to-back closing pairs with the extremes swapped.
    send_pair(8'hff, 8'h00, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_pair(8'h00, 8'hff, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
    send_pair(8'haa, 8'h55, 16'sd0, -16'sd1, -16'sd1, 16'sd0, 1'b1);
    wait_drained();

    send_random_vectors(1200);
    wait_drained();

    // One long vector with large magnitudes.
    for (int unsigned i = 0; i < LongPairs; i++) begin
      send_pair(($urandom_range(0, 3) == 0) ? pick_byte() : 8'hff,
                ($urandom_range(0, 3) == 0) ? pick_byte() : 8'hff,
                -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, i == LongPairs - 1);
    end
    wait_drained();

    idle_on = 1'b0;
    send_random_vectors(200);
    wait_drained();

    $display("covered %0d byte pairs and %0d dot products, including corner coefficients,",
             sb.pairs_taken, sb.sums_checked);
    $display("mid-block coefficient changes and a %0d-pair vector; %0d mismatches",
             LongPairs, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
